@@ rtl/ubd_pkg.sv @@
// Shared types and constants of the byte-order-mark detecting UTF-8 transcoder.
package ubd_pkg;

	localparam int MaxOut = 6;

	typedef enum logic [2:0] {
		ENC_UTF8  = 3'd0,
		ENC_U16LE = 3'd1,
		ENC_U16BE = 3'd2,
		ENC_U32LE = 3'd3,
		ENC_U32BE = 3'd4
	} enc_t;

	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [2:0]             cnt;
		logic                   valid;
	} res_t;

endpackage

@@ rtl/unicode_bom_detect_to_utf8_top.sv @@
// Top level of the byte-order-mark detecting UTF-8 transcoder.
//
// Input stream: one transfer is either a data byte (s_axis_tuser low, byte in
// s_axis_tdata) or an end-of-stream marker (s_axis_tuser high, tdata ignored).
// The first four bytes of a stream are held until the encoding is known; the
// mark is dropped and the held bytes are replayed, all within that item.
// Output stream: UTF-8 bytes, m_axis_tlast high on the last byte produced by
// one input item. An item can give zero to six bytes.
// An accepted item is registered in the input register and then in the result
// register, which offers its first output byte.
// Throughput: one output byte per cycle while the receiver is ready; an item
// that gives bytes holds the result register until its last byte transfers.
// Items that give no bytes need no output slot and go by at one per cycle.
// Reset empties both registers and restarts encoding detection; an
// end-of-stream item flushes the held bytes and restarts detection as well.
// When the receiver stalls, the current byte holds; the input register passes
// items that give no bytes, holds the next one that does, and s_axis_tready
// stays low until the last byte of the held result transfers.
module unicode_bom_detect_to_utf8_top
	import ubd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tuser,  // [0] op: end of stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] utf8_byte
	output logic       m_axis_tlast
);

	res_t res;
	logic res_ready;

	ubd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.res       (res),
		.res_ready (res_ready)
	);

	ubd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ rtl/ubd_decode.sv @@
// Input register, stream state and single-pass decode of one item into its UTF-8 bytes.
module ubd_decode
	import ubd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_op,
	input  logic [7:0] in_byte,
	output res_t res,
	input  logic res_ready
);

	typedef enum logic [1:0] {M_NONE, M_RAW, M_U16, M_U32} mode_t;

	typedef struct packed {
		enc_t       enc;
		logic [2:0] drop;
	} det_t;

	typedef struct packed {
		logic        force4;
		logic [20:0] val;
	} cp_t;

	typedef struct packed {
		logic       pend;
		logic [9:0] half;
		logic [1:0] n;
		cp_t        cp0;
		cp_t        cp1;
	} take_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} seq_t;

	localparam logic [20:0] CpRepl = 21'h00FFFD;
	localparam logic [20:0] CpSuppBase = 21'h010000;

	function automatic det_t detect(input logic [3:0][7:0] h, input logic [2:0] n);
		det_t d;
		d.enc = ENC_UTF8;
		d.drop = 3'd0;
		if (n >= 3'd4 && h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'hFE && h[3] == 8'hFF) begin
			d.enc = ENC_U32BE;
			d.drop = 3'd4;
		end else if (n >= 3'd4 && h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h00) begin
			d.enc = ENC_U32BE;
		end else if (n >= 3'd4 && h[0] == 8'hFF && h[1] == 8'hFE && h[2] == 8'h00
				&& h[3] == 8'h00) begin
			d.enc = ENC_U32LE;
			d.drop = 3'd4;
		end else if (n >= 3'd4 && h[1] == 8'h00 && h[2] == 8'h00 && h[3] == 8'h00) begin
			d.enc = ENC_U32LE;
		end else if (n >= 3'd2 && h[0] == 8'hFE && h[1] == 8'hFF) begin
			d.enc = ENC_U16BE;
			d.drop = 3'd2;
		end else if (n >= 3'd2 && h[0] == 8'h00) begin
			d.enc = ENC_U16BE;
		end else if (n >= 3'd2 && h[0] == 8'hFF && h[1] == 8'hFE) begin
			d.enc = ENC_U16LE;
			d.drop = 3'd2;
		end else if (n >= 3'd2 && h[1] == 8'h00) begin
			d.enc = ENC_U16LE;
		end else if (n >= 3'd3 && h[0] == 8'hEF && h[1] == 8'hBB && h[2] == 8'hBF) begin
			d.drop = 3'd3;
		end
		return d;
	endfunction

	function automatic take_t take16(input logic pend, input logic [9:0] half,
			input logic [15:0] u);
		take_t t;
		logic is_low;
		logic is_high;
		cp_t solo;
		is_low = u inside {[16'hDC00:16'hDFFF]};
		is_high = u inside {[16'hD800:16'hDBFF]};
		t.pend = 1'b0;
		t.half = 10'd0;
		t.n = 2'd0;
		t.cp0 = '0;
		t.cp1 = '0;
		solo.force4 = 1'b0;
		solo.val = is_low ? CpRepl : {5'd0, u};
		if (pend && is_low) begin
			t.n = 2'd1;
			t.cp0.val = {1'b0, half, u[9:0]} + CpSuppBase;
		end else if (pend) begin
			t.cp0.val = CpRepl;
			if (is_high) begin
				t.n = 2'd1;
				t.pend = 1'b1;
				t.half = u[9:0];
			end else begin
				t.n = 2'd2;
				t.cp1 = solo;
			end
		end else if (is_high) begin
			t.pend = 1'b1;
			t.half = u[9:0];
		end else begin
			t.n = 2'd1;
			t.cp0 = solo;
		end
		return t;
	endfunction

	function automatic seq_t enc_cp(input cp_t c);
		seq_t s;
		logic [20:0] v;
		v = (!c.force4 && c.val == 21'd4) ? CpRepl : c.val;
		s.bytes = '0;
		if (c.force4 || v[20:16] != 5'd0) begin
			s.len = 3'd4;
			s.bytes[0] = {5'b11110, v[20:18]};
			s.bytes[1] = {2'b10, v[17:12]};
			s.bytes[2] = {2'b10, v[11:6]};
			s.bytes[3] = {2'b10, v[5:0]};
		end else if (v[15:11] != 5'd0) begin
			s.len = 3'd3;
			s.bytes[0] = {4'b1110, v[15:12]};
			s.bytes[1] = {2'b10, v[11:6]};
			s.bytes[2] = {2'b10, v[5:0]};
		end else if (v[10:7] != 4'd0) begin
			s.len = 3'd2;
			s.bytes[0] = {3'b110, v[10:6]};
			s.bytes[1] = {2'b10, v[5:0]};
		end else begin
			s.len = 3'd1;
			s.bytes[0] = {1'b0, v[6:0]};
		end
		return s;
	endfunction

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	logic [2:0][7:0] hdr_q;
	logic [1:0]      hdr_cnt_q;
	logic            detecting_q;
	enc_t            enc_q;
	logic [2:0][7:0] unit_q;
	logic [1:0]      ucnt_q;
	logic [9:0]      hhalf_q;
	logic            hpend_q;

	logic [1:0] hdr_cnt_d;
	logic       detecting_d;
	enc_t       enc_d;
	logic [1:0] ucnt_d;
	logic [9:0] hhalf_d;
	logic       hpend_d;

	logic                   proc;
	logic                   replay;
	mode_t                  mode;
	logic [3:0][7:0]        h;
	logic [2:0]             hn;
	logic [2:0]             rem;
	det_t                   det;
	logic [15:0]            p0;
	logic [15:0]            p1;
	logic [5:0][7:0]        raw;
	logic [2:0]             raw_n;
	logic [15:0]            ua;
	logic [15:0]            ub;
	logic [1:0]             nu;
	logic                   pend_in;
	logic [9:0]             half_in;
	logic [31:0]            w;
	take_t                  t1;
	take_t                  t2;
	logic [1:0]             n1;
	logic [1:0]             n2;
	logic [1:0]             ncp;
	cp_t                    cpa;
	cp_t                    cpb;
	seq_t                   sa;
	seq_t                   sb;
	logic [2:0]             lena;
	logic [2:0]             lenb;
	logic [MaxOut-1:0][7:0] obytes;
	logic [2:0]             ocnt;
	logic                   fin_pend;
	logic [9:0]             fin_half;

	always_comb begin
		h = {byte_s1, hdr_q[2], hdr_q[1], hdr_q[0]};
		hn = op_s1 ? {1'b0, hdr_cnt_q} : 3'd4;
		replay = detecting_q && (op_s1 || hdr_cnt_q == 2'd3);
		det = detect(h, hn);
		rem = hn - det.drop;
		p0 = (det.enc == ENC_U16BE) ? {h[0], h[1]} : {h[1], h[0]};
		p1 = (det.enc == ENC_U16BE) ? {h[2], h[3]} : {h[3], h[2]};

		mode = M_NONE;
		raw = {16'd0, h};
		raw_n = 3'd0;
		ua = '0;
		ub = '0;
		nu = 2'd0;
		pend_in = hpend_q;
		half_in = hhalf_q;
		w = '0;

		if (detecting_q) begin
			pend_in = 1'b0;
			half_in = '0;
			if (replay) begin
				case (det.enc)
					ENC_U16LE, ENC_U16BE: begin
						mode = M_U16;
						ua = (det.drop == 3'd0) ? p0 : p1;
						ub = p1;
						nu = rem[2:1];
					end
					ENC_U32LE, ENC_U32BE: begin
						if (rem[2]) begin
							mode = M_U32;
						end
						w = (det.enc == ENC_U32BE) ? {h[0], h[1], h[2], h[3]} : h;
					end
					default: begin
						mode = M_RAW;
						raw = (det.drop == 3'd0) ? {16'd0, h} : {40'd0, h[3]};
						raw_n = rem;
					end
				endcase
			end
		end else if (!op_s1) begin
			case (enc_q)
				ENC_U16LE, ENC_U16BE: begin
					if (ucnt_q != 2'd0) begin
						mode = M_U16;
						nu = 2'd1;
					end
					ua = (enc_q == ENC_U16BE) ? {unit_q[0], byte_s1} : {byte_s1, unit_q[0]};
				end
				ENC_U32LE, ENC_U32BE: begin
					if (ucnt_q == 2'd3) begin
						mode = M_U32;
					end
					w = (enc_q == ENC_U32BE) ? {unit_q[0], unit_q[1], unit_q[2], byte_s1}
						: {byte_s1, unit_q[2], unit_q[1], unit_q[0]};
				end
				default: begin
					mode = M_RAW;
					raw = {40'd0, byte_s1};
					raw_n = 3'd1;
				end
			endcase
		end

		t1 = take16(pend_in, half_in, ua);
		t2 = take16(t1.pend, t1.half, ub);
		n1 = (nu != 2'd0) ? t1.n : 2'd0;
		n2 = (nu == 2'd2) ? t2.n : 2'd0;
		fin_pend = (nu == 2'd2) ? t2.pend : ((nu == 2'd1) ? t1.pend : pend_in);
		fin_half = (nu == 2'd2) ? t2.half : ((nu == 2'd1) ? t1.half : half_in);

		if (mode == M_U32) begin
			cpa.force4 = |w[31:21];
			cpa.val = w[20:0];
			cpb = '0;
			ncp = 2'd1;
		end else begin
			cpa = (n1 != 2'd0) ? t1.cp0 : t2.cp0;
			cpb = (n1 == 2'd2) ? t1.cp1 : ((n1 == 2'd1) ? t2.cp0 : t2.cp1);
			ncp = n1 + n2;
		end
		sa = enc_cp(cpa);
		sb = enc_cp(cpb);

		lena = 3'd0;
		lenb = 3'd0;
		if (mode == M_U16 || mode == M_U32) begin
			if (ncp != 2'd0) begin
				lena = sa.len;
			end
			if (ncp == 2'd2) begin
				lenb = sb.len;
			end
		end
		for (int k = 0; k < MaxOut; k++) begin
			if (mode == M_RAW) begin
				obytes[k] = raw[k];
			end else if (3'(k) < lena) begin
				obytes[k] = sa.bytes[2'(k)];
			end else begin
				obytes[k] = sb.bytes[2'(3'(k) - lena)];
			end
		end
		case (mode)
			M_RAW: ocnt = raw_n;
			M_U16, M_U32: ocnt = lena + lenb;
			default: ocnt = 3'd0;
		endcase

		proc = valid_s1 && (ocnt == 3'd0 || res_ready);
		in_ready = !valid_s1 || proc;
		res.bytes = obytes;
		res.cnt = ocnt;
		res.valid = valid_s1 && ocnt != 3'd0;

		detecting_d = detecting_q;
		enc_d = enc_q;
		hdr_cnt_d = hdr_cnt_q;
		ucnt_d = ucnt_q;
		hpend_d = hpend_q;
		hhalf_d = hhalf_q;
		if (mode == M_U16) begin
			hpend_d = fin_pend;
			hhalf_d = fin_half;
		end
		if (op_s1) begin
			detecting_d = 1'b1;
			enc_d = ENC_UTF8;
			hdr_cnt_d = 2'd0;
			ucnt_d = 2'd0;
			hpend_d = 1'b0;
			hhalf_d = 10'd0;
		end else if (detecting_q) begin
			if (replay) begin
				detecting_d = 1'b0;
				enc_d = det.enc;
				hdr_cnt_d = 2'd0;
				ucnt_d = 2'd0;
			end else begin
				hdr_cnt_d = hdr_cnt_q + 2'd1;
			end
		end else begin
			case (enc_q)
				ENC_U16LE, ENC_U16BE: ucnt_d = {1'b0, ~ucnt_q[0]};
				ENC_U32LE, ENC_U32BE: ucnt_d = ucnt_q + 2'd1;
				default: ucnt_d = ucnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			detecting_q <= 1'b1;
			enc_q <= ENC_UTF8;
			hdr_cnt_q <= 2'd0;
			ucnt_q <= 2'd0;
			hpend_q <= 1'b0;
			hhalf_q <= 10'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (proc) begin
				detecting_q <= detecting_d;
				enc_q <= enc_d;
				hdr_cnt_q <= hdr_cnt_d;
				ucnt_q <= ucnt_d;
				hpend_q <= hpend_d;
				hhalf_q <= hhalf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= in_op;
			byte_s1 <= in_byte;
		end
		if (proc && !op_s1) begin
			if (detecting_q && !replay) begin
				hdr_q[hdr_cnt_q] <= byte_s1;
			end
			if (!detecting_q && (enc_q == ENC_U16LE || enc_q == ENC_U16BE)
					&& ucnt_q == 2'd0) begin
				unit_q[0] <= byte_s1;
			end
			if (!detecting_q && (enc_q == ENC_U32LE || enc_q == ENC_U32BE)
					&& ucnt_q != 2'd3) begin
				unit_q[ucnt_q] <= byte_s1;
			end
		end
	end

	a_hdr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!detecting_q |-> hdr_cnt_q == 2'd0)
		else $error("header count left nonzero after detection");

	a_fresh_decoder: assert property (@(posedge clk) disable iff (!arst_n)
		detecting_q |-> (ucnt_q == 2'd0 && !hpend_q))
		else $error("unit state busy while still detecting");

	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && op_s1) |=> (detecting_q && enc_q == ENC_UTF8 && hdr_cnt_q == 2'd0))
		else $error("end of stream did not restart detection");

endmodule

@@ rtl/ubd_emit.sv @@
// Result register that holds one item's UTF-8 bytes and sends them one transfer at a time.
module ubd_emit
	import ubd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  res_t res,
	output logic res_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic out_last
);

	logic [MaxOut-1:0][7:0] obuf_s2;
	logic [2:0]             cnt_s2;
	logic                   valid_s2;
	logic [2:0]             idx_q;
	logic                   done;

	always_comb begin
		out_valid = valid_s2;
		out_byte = obuf_s2[idx_q];
		out_last = (idx_q == cnt_s2 - 3'd1);
		done = valid_s2 && out_ready && out_last;
		res_ready = !valid_s2 || done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= 3'd0;
		end else if (res.valid && res_ready) begin
			valid_s2 <= 1'b1;
			idx_q <= 3'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
			idx_q <= 3'd0;
		end else if (valid_s2 && out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			obuf_s2 <= res.bytes;
			cnt_s2 <= res.cnt;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != 3'd0 && cnt_s2 <= 3'(MaxOut)))
		else $error("held result has no bytes or too many");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_q < cnt_s2)
		else $error("byte index past end of held result");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_ready && !out_last) |=> (valid_s2 && idx_q == $past(idx_q) + 3'd1))
		else $error("byte index did not advance after a transfer");

endmodule

@@ tb/unicode_bom_detect_to_utf8_top_tb.sv @@
// Self-checking bench for the byte-order-mark detecting UTF-8 transcoder.
module unicode_bom_detect_to_utf8_top_tb
	import ubd_pkg::*;
();

	localparam bit        OP_DATA  = 1'b0;
	localparam bit        OP_EOS   = 1'b1;
	localparam bit [31:0] CP_FOUR  = 32'h4;
	localparam bit [31:0] CP_REPL  = 32'hFFFD;
	localparam bit [15:0] BOM16    = 16'hFEFF;
	localparam bit [31:0] BOM32    = 32'h0000FEFF;
	localparam int        RANDOM_ITEMS = 430;

	typedef struct {
		bit       op;
		bit [7:0] data;
	} stim_t;

	class utf8_scoreboard;
		bit [7:0]    hdr [4];
		int unsigned hdr_cnt;
		bit          detecting;
		enc_t        enc;
		bit [7:0]    unit_b [3];
		int unsigned unit_cnt;
		bit [9:0]    hi_half;
		bit          hi_pend;
		bit [7:0]    item_bytes [$];
		bit [8:0]    expected_utf8 [$];
		int unsigned fails;

		function new();
			restart();
			fails = 0;
		endfunction

		function void restart();
			hdr_cnt = 0;
			detecting = 1'b1;
			enc = ENC_UTF8;
			unit_cnt = 0;
			hi_half = '0;
			hi_pend = 1'b0;
		endfunction

		function void add_out(bit [7:0] b);
			item_bytes.insert(item_bytes.size(), b);
		endfunction

		function void emit_cp(bit [31:0] cp);
			if (cp == CP_FOUR)
				cp = CP_REPL;
			if (cp < 32'h80) begin
				add_out(cp[7:0]);
			end else if (cp < 32'h800) begin
				add_out({3'b110, cp[10:6]});
				add_out({2'b10, cp[5:0]});
			end else if (cp < 32'h10000) begin
				add_out({4'b1110, cp[15:12]});
				add_out({2'b10, cp[11:6]});
				add_out({2'b10, cp[5:0]});
			end else begin
				add_out({5'b11110, cp[20:18]});
				add_out({2'b10, cp[17:12]});
				add_out({2'b10, cp[11:6]});
				add_out({2'b10, cp[5:0]});
			end
		endfunction

		function void take_unit16(bit [15:0] u);
			bit is_low;
			bit is_high;
			is_low = (u >= 16'hDC00) && (u < 16'hE000);
			is_high = (u >= 16'hD800) && (u < 16'hDC00);
			if (hi_pend) begin
				hi_pend = 1'b0;
				if (is_low) begin
					emit_cp({12'd0, hi_half, u[9:0]} + 32'h10000);
					hi_half = '0;
					return;
				end
				hi_half = '0;
				emit_cp(CP_REPL);
			end
			if (is_low) begin
				emit_cp(CP_REPL);
			end else if (is_high) begin
				hi_pend = 1'b1;
				hi_half = u[9:0];
			end else begin
				emit_cp({16'd0, u});
			end
		endfunction

		function void feed(bit [7:0] b);
			case (enc)
				ENC_U16LE, ENC_U16BE: begin
					if (unit_cnt == 0) begin
						unit_b[0] = b;
						unit_cnt = 1;
					end else begin
						unit_cnt = 0;
						take_unit16(enc == ENC_U16BE ? {unit_b[0], b} : {b, unit_b[0]});
					end
				end
				ENC_U32LE, ENC_U32BE: begin
					if (unit_cnt < 3) begin
						unit_b[unit_cnt] = b;
						unit_cnt++;
					end else begin
						unit_cnt = 0;
						emit_cp(enc == ENC_U32BE ? {unit_b[0], unit_b[1], unit_b[2], b}
							: {b, unit_b[2], unit_b[1], unit_b[0]});
					end
				end
				default: begin
					add_out(b);
				end
			endcase
		endfunction

		function int unsigned detect(int unsigned n);
			if (n >= 4) begin
				if (hdr[0] == 8'h00 && hdr[1] == 8'h00 && hdr[2] == 8'hFE && hdr[3] == 8'hFF) begin
					enc = ENC_U32BE;
					return 4;
				end
				if (hdr[0] == 8'h00 && hdr[1] == 8'h00 && hdr[2] == 8'h00) begin
					enc = ENC_U32BE;
					return 0;
				end
				if (hdr[0] == 8'hFF && hdr[1] == 8'hFE && hdr[2] == 8'h00 && hdr[3] == 8'h00) begin
					enc = ENC_U32LE;
					return 4;
				end
				if (hdr[1] == 8'h00 && hdr[2] == 8'h00 && hdr[3] == 8'h00) begin
					enc = ENC_U32LE;
					return 0;
				end
			end
			if (n >= 2) begin
				if (hdr[0] == 8'hFE && hdr[1] == 8'hFF) begin
					enc = ENC_U16BE;
					return 2;
				end
				if (hdr[0] == 8'h00) begin
					enc = ENC_U16BE;
					return 0;
				end
				if (hdr[0] == 8'hFF && hdr[1] == 8'hFE) begin
					enc = ENC_U16LE;
					return 2;
				end
				if (hdr[1] == 8'h00) begin
					enc = ENC_U16LE;
					return 0;
				end
			end
			enc = ENC_UTF8;
			if (n >= 3 && hdr[0] == 8'hEF && hdr[1] == 8'hBB && hdr[2] == 8'hBF)
				return 3;
			return 0;
		endfunction

		function void finish_detect(int unsigned n);
			int unsigned i;
			i = detect(n);
			detecting = 1'b0;
			while (i < n) begin
				feed(hdr[i]);
				i++;
			end
		endfunction

		function void note_item(bit op, bit [7:0] d);
			bit lst;
			item_bytes.delete();
			if (op == OP_DATA) begin
				if (detecting) begin
					hdr[hdr_cnt % 4] = d;
					hdr_cnt++;
					if (hdr_cnt >= 4)
						finish_detect(4);
				end else begin
					feed(d);
				end
			end else begin
				if (detecting)
					finish_detect(hdr_cnt);
				restart();
			end
			foreach (item_bytes[k]) begin
				lst = (k == item_bytes.size() - 1);
				expected_utf8.insert(expected_utf8.size(), {lst, item_bytes[k]});
			end
		endfunction

		function void fail_note(string msg);
			if (fails < 10)
				$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endfunction

		function void check_byte(bit [7:0] b, bit lst);
			bit [8:0] exp_v;
			if (expected_utf8.size() == 0) begin
				fail_note($sformatf("byte %02h last %0b arrived with nothing outstanding", b, lst));
				return;
			end
			exp_v = expected_utf8[0];
			expected_utf8.delete(0);
			if (exp_v[7:0] != b)
				fail_note($sformatf("utf8 byte expected %02h actual %02h", exp_v[7:0], b));
			if (exp_v[8] != lst)
				fail_note($sformatf("tlast expected %0b actual %0b (byte %02h)", exp_v[8], lst, b));
		endfunction

		function int unsigned pending();
			return expected_utf8.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	utf8_scoreboard utf8_sb;
	stim_t          stim_q [$];
	bit             tx_calm = 1'b0;
	bit             rx_calm = 1'b0;

	unicode_bom_detect_to_utf8_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_byte(bit [7:0] b);
		stim_t it;
		it.op = OP_DATA;
		it.data = b;
		stim_q.insert(stim_q.size(), it);
	endfunction

	function automatic void add_eos();
		stim_t it;
		it.op = OP_EOS;
		it.data = 8'($urandom);
		stim_q.insert(stim_q.size(), it);
	endfunction

	function automatic void add_u16(bit be, bit [15:0] u);
		if (be) begin
			add_byte(u[15:8]);
			add_byte(u[7:0]);
		end else begin
			add_byte(u[7:0]);
			add_byte(u[15:8]);
		end
	endfunction

	function automatic void add_u32(bit be, bit [31:0] u);
		if (be) begin
			add_u16(1'b1, u[31:16]);
			add_u16(1'b1, u[15:0]);
		end else begin
			add_u16(1'b0, u[15:0]);
			add_u16(1'b0, u[31:16]);
		end
	endfunction

	function automatic bit [7:0] pick_hdr_byte();
		case ($urandom_range(0, 6))
			0: return 8'h00;
			1: return 8'hFE;
			2: return 8'hFF;
			3: return 8'hEF;
			4: return 8'hBB;
			5: return 8'hBF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic bit [15:0] pick_u16();
		case ($urandom_range(0, 7))
			0: return 16'($urandom_range(32'h20, 32'h7E));
			1: return CP_FOUR[15:0];
			2, 3: return 16'($urandom);
			4: return 16'($urandom_range(32'hDC00, 32'hDFFF));
			5: return 16'($urandom_range(32'hD800, 32'hDBFF));
			6: return 16'($urandom_range(32'h80, 32'h7FF));
			default: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
		endcase
	endfunction

	function automatic bit [31:0] pick_u32();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 32'h7F);
			1: return CP_FOUR;
			2: return $urandom_range(32'h80, 32'h7FF);
			3: return $urandom_range(32'h800, 32'hFFFF);
			4: return $urandom_range(32'h10000, 32'h10FFFF);
			5: return $urandom;
			6: return $urandom_range(32'hD800, 32'hDFFF);
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h0;
					1: return 32'h7F;
					2: return 32'h80;
					3: return 32'h7FF;
					4: return 32'hFFFF;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic void gen_stream();
		int unsigned kind;
		int unsigned units;
		bit          be;
		kind = $urandom_range(0, 9);
		units = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
		be = 1'($urandom_range(0, 1));
		case (kind)
			0, 1: begin
				if (kind == 0) begin
					add_byte(8'hEF);
					add_byte(8'hBB);
					add_byte(8'hBF);
				end
				repeat (units * 2)
					add_byte($urandom_range(0, 3) == 0 ? 8'($urandom)
						: 8'($urandom_range(32'h20, 32'h7E)));
			end
			2, 3, 8: begin
				if (kind == 3)
					add_u16(be, 16'($urandom_range(1, 255)));
				else
					add_u16(be, BOM16);
				repeat (units) begin
					if ($urandom_range(0, 4) == 0) begin
						add_u16(be, 16'($urandom_range(32'hD800, 32'hDBFF)));
						add_u16(be, 16'($urandom_range(32'hDC00, 32'hDFFF)));
					end else begin
						add_u16(be, pick_u16());
					end
				end
				case ($urandom_range(0, 5))
					0: add_byte(8'($urandom));
					1: add_u16(be, 16'($urandom_range(32'hD800, 32'hDBFF)));
					default: ;
				endcase
			end
			4, 5, 9: begin
				if (kind == 5)
					add_u32(be, $urandom_range(1, 255));
				else
					add_u32(be, BOM32);
				repeat (units)
					add_u32(be, pick_u32());
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						add_byte(8'($urandom));
			end
			6: begin
				repeat ($urandom_range(0, 3))
					add_byte(pick_hdr_byte());
			end
			default: begin
				repeat ($urandom_range(4, 10))
					add_byte(pick_hdr_byte());
			end
		endcase
		add_eos();
	endfunction

	function automatic void add_directed();
		add_u16(1'b0, BOM16);
		add_u16(1'b0, CP_FOUR[15:0]);
		add_u16(1'b0, 16'hDC00);
		add_u16(1'b0, 16'hD83D);
		add_u16(1'b0, 16'h0041);
		add_u16(1'b0, 16'hD83D);
		add_u16(1'b0, 16'hDE00);
		add_byte(8'h41);
		add_eos();
		add_byte(8'hEF);
		add_byte(8'hBB);
		add_byte(8'hBF);
		add_eos();
		add_eos();
		add_byte(8'hFE);
		add_byte(8'hFF);
		add_eos();
	endfunction

	task automatic send_item(stim_t it);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= it.data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (!tx_calm && $urandom_range(0, 99) >= 65) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic send_queue();
		stim_t it;
		while (stim_q.size() != 0) begin
			if ($urandom_range(0, 49) == 0)
				tx_calm = !tx_calm;
			it = stim_q[0];
			stim_q.delete(0);
			send_item(it);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				utf8_sb.note_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				utf8_sb.check_byte(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin : utf8_sink
		int hold;
		int seen;
		bit pressed;
		hold = 0;
		seen = 0;
		pressed = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				seen++;
			if ($urandom_range(0, 149) == 0)
				rx_calm = !rx_calm;
			if (!pressed && seen >= 60) begin
				pressed = 1'b1;
				hold = 200;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_calm || $urandom_range(0, 99) < 70) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
			end
		end
	end

	initial begin : byte_source
		utf8_sb = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_DATA;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_directed();
		send_queue();
		while (stim_q.size() < RANDOM_ITEMS)
			gen_stream();
		send_queue();
		s_axis_tvalid <= 1'b0;
		while (utf8_sb.pending() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (utf8_sb.fails == 0 && utf8_sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
